@@ hdl/stopwatch_and_echo_ranger_core_macros.svh @@
// ----------------------------------------------------------------------------
// stopwatch and echo ranger assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef STOPWATCH_AND_ECHO_RANGER_CORE_MACROS_SVH
`define STOPWATCH_AND_ECHO_RANGER_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define SEWR_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SEWR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/sewr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sewr_pkg
// shared types, codes and constants of the stopwatch and echo ranger
// ----------------------------------------------------------------------------
package sewr_pkg;

  localparam int LAP_SLOTS_DEF = 3;
  localparam int PC_W          = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [16:0] WRAP_LAST = 17'd99999;
  localparam logic [15:0] ECHO_MAX  = 16'hFFFF;

  // event codes
  localparam logic [2:0] EV_TICK  = 3'd0;
  localparam logic [2:0] EV_PAUSE = 3'd1;
  localparam logic [2:0] EV_LAP   = 3'd2;
  localparam logic [2:0] EV_MODE  = 3'd3;
  localparam logic [2:0] EV_RISE  = 3'd4;
  localparam logic [2:0] EV_FALL  = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TPU   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL  = 2'd2;

  localparam logic [7:0] TPU_RST   = 8'd1;
  localparam logic [7:0] FLOOR_RST = 8'd2;
  localparam logic [7:0] CEIL_RST  = 8'd20;

  // datapath operations
  localparam logic [2:0] DP_WAIT   = 3'd0;
  localparam logic [2:0] DP_UPDATE = 3'd1;
  localparam logic [2:0] DP_DIVINI = 3'd2;
  localparam logic [2:0] DP_DIVSTP = 3'd3;
  localparam logic [2:0] DP_CLAMP  = 3'd4;
  localparam logic [2:0] DP_DIGLD  = 3'd5;
  localparam logic [2:0] DP_DIGSTP = 3'd6;
  localparam logic [2:0] DP_EMIT   = 3'd7;

  // sequencer branch conditions
  localparam logic [2:0] C_NEXT  = 3'd0;
  localparam logic [2:0] C_IN    = 3'd1;
  localparam logic [2:0] C_LOOP  = 3'd2;
  localparam logic [2:0] C_RANGE = 3'd3;
  localparam logic [2:0] C_GOTO  = 3'd4;
  localparam logic [2:0] C_OUT   = 3'd5;
  localparam logic [2:0] C_REM   = 3'd6;

  typedef struct packed {
    logic [2:0]      op;
    logic [3:0]      csel;
    logic [1:0]      dsel;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic loop_done;
    logic ranging;
  } status_t;

  typedef struct packed {
    logic [7:0] ticks_per_unit;
    logic [7:0] distance_floor;
    logic [7:0] distance_ceiling;
  } cfg_t;

  typedef struct packed {
    logic        ranging_active;
    logic [3:0]  digit_three;
    logic [3:0]  digit_two;
    logic [3:0]  digit_one;
    logic [3:0]  digit_zero;
    logic [1:0]  lap_phase_out;
    logic        paused_out;
    logic [7:0]  distance_out;
    logic [10:0] pwm_compare;
    logic        trigger_pulse;
  } res_t;

  // decade weights times 8, 4, 2, 1 for the digit steps
  function automatic logic [16:0] scaled_const(input logic [3:0] idx);
    logic [16:0] k;
    case (idx)
      4'd0:    k = 17'd80000;
      4'd1:    k = 17'd40000;
      4'd2:    k = 17'd20000;
      4'd3:    k = 17'd10000;
      4'd4:    k = 17'd8000;
      4'd5:    k = 17'd4000;
      4'd6:    k = 17'd2000;
      4'd7:    k = 17'd1000;
      4'd8:    k = 17'd800;
      4'd9:    k = 17'd400;
      4'd10:   k = 17'd200;
      4'd11:   k = 17'd100;
      4'd12:   k = 17'd80;
      4'd13:   k = 17'd40;
      4'd14:   k = 17'd20;
      4'd15:   k = 17'd10;
      default: k = 17'd10;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/sewr_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sewr_in_if
// event channel: valid, ready and one event item
// ----------------------------------------------------------------------------
interface sewr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [1:0] lap_select;

  modport source (output valid, output operation, output lap_select, input ready);
  modport sink   (input valid, input operation, input lap_select, output ready);
endinterface

@@ hdl/sewr_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sewr_out_if
// result channel: valid, ready and one display item
// ----------------------------------------------------------------------------
interface sewr_out_if;
  logic        valid;
  logic        ready;
  logic        ranging_active;
  logic [3:0]  digit_three;
  logic [3:0]  digit_two;
  logic [3:0]  digit_one;
  logic [3:0]  digit_zero;
  logic [1:0]  lap_phase_out;
  logic        paused_out;
  logic [7:0]  distance_out;
  logic [10:0] pwm_compare;
  logic        trigger_pulse;

  modport source (
    output valid, output ranging_active, output digit_three, output digit_two,
    output digit_one, output digit_zero, output lap_phase_out, output paused_out,
    output distance_out, output pwm_compare, output trigger_pulse, input ready
  );
  modport sink (
    input valid, input ranging_active, input digit_three, input digit_two,
    input digit_one, input digit_zero, input lap_phase_out, input paused_out,
    input distance_out, input pwm_compare, input trigger_pulse, output ready
  );
endinterface

@@ hdl/sewr_useq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sewr_useq
// step counter and microcode rom with conditional jumps
// ----------------------------------------------------------------------------
module sewr_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  sewr_pkg::status_t stat,
  output sewr_pkg::ctrl_t   ctrl
);
  import sewr_pkg::*;

  localparam logic [PC_W-1:0] PC_DIV    = 5'd3;
  localparam logic [PC_W-1:0] PC_EMIT   = 5'd22;
  localparam logic [PC_W-1:0] PC_RANGE  = 5'd23;
  localparam logic [PC_W-1:0] PC_IDLE   = 5'd0;

  logic [PC_W-1:0] pc_r, pc_nxt;

  function automatic ctrl_t mk(input logic [2:0] op, input logic [3:0] csel,
                               input logic [1:0] dsel, input logic [2:0] cond,
                               input logic [PC_W-1:0] target);
    ctrl_t w;
    w.op     = op;
    w.csel   = csel;
    w.dsel   = dsel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t       w;
    logic [3:0]  idx;
    idx = 4'(pc - 5'd6);
    case (pc) inside
      5'd0:           w = mk(DP_WAIT,   4'd0, 2'd0, C_IN,    PC_IDLE);
      5'd1:           w = mk(DP_UPDATE, 4'd0, 2'd0, C_NEXT,  PC_IDLE);
      5'd2:           w = mk(DP_DIVINI, 4'd0, 2'd0, C_NEXT,  PC_IDLE);
      5'd3:           w = mk(DP_DIVSTP, 4'd0, 2'd0, C_LOOP,  PC_DIV);
      5'd4:           w = mk(DP_CLAMP,  4'd0, 2'd0, C_NEXT,  PC_IDLE);
      5'd5:           w = mk(DP_DIGLD,  4'd0, 2'd0, C_RANGE, PC_RANGE);
      // stopwatch: four weights per digit, most significant first
      [5'd6:5'd21]:   w = mk(DP_DIGSTP, idx, 2'(2'd3 - idx[3:2]), C_NEXT, PC_IDLE);
      5'd22:          w = mk(DP_EMIT,   4'd0, 2'd0, C_OUT,   PC_IDLE);
      // ranging: hundreds take two weights, tens four, ones are the remainder
      5'd23:          w = mk(DP_DIGSTP, 4'd10, 2'd2, C_NEXT, PC_IDLE);
      5'd24:          w = mk(DP_DIGSTP, 4'd11, 2'd2, C_NEXT, PC_IDLE);
      [5'd25:5'd28]:  w = mk(DP_DIGSTP, 4'(pc - 5'd13), 2'd1, C_NEXT, PC_IDLE);
      5'd29:          w = mk(DP_DIGSTP, 4'd0, 2'd0, C_REM,  PC_EMIT);
      default:        w = mk(DP_WAIT,   4'd0, 2'd0, C_GOTO, PC_IDLE);
    endcase
    return w;
  endfunction

  assign ctrl = ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      C_NEXT:  pc_nxt = pc_r + 5'd1;
      C_IN:    pc_nxt = stat.in_fire ? pc_r + 5'd1 : pc_r;
      C_LOOP:  pc_nxt = stat.loop_done ? pc_r + 5'd1 : ctrl.target;
      C_RANGE: pc_nxt = stat.ranging ? ctrl.target : pc_r + 5'd1;
      C_GOTO:  pc_nxt = ctrl.target;
      C_OUT:   pc_nxt = stat.out_free ? ctrl.target : pc_r;
      C_REM:   pc_nxt = ctrl.target;
      default: pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ hdl/sewr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sewr_datapath
// timer state, shift-subtract divider, clamp and bcd digit unit
// ----------------------------------------------------------------------------
`include "stopwatch_and_echo_ranger_core_macros.svh"

module sewr_datapath #(
  parameter int LAP_SLOTS = sewr_pkg::LAP_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sewr_pkg::ctrl_t ctrl,
  input  logic            in_fire,
  input  logic [2:0]      in_operation,
  input  logic [1:0]      in_lap_select,
  input  sewr_pkg::cfg_t  cfg,
  output logic            loop_done,
  output logic            ranging,
  output sewr_pkg::res_t  res
);
  import sewr_pkg::*;

  localparam int LW = $clog2(LAP_SLOTS + 1);
  localparam int IW = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
  localparam logic [LW-1:0] LAST_PHASE = LW'(LAP_SLOTS);

  // event item and architectural state
  logic [2:0]    op_r;
  logic [1:0]    sel_r;
  logic          mode_r, mode_nxt;
  logic          paused_r, paused_nxt;
  logic [16:0]   elapsed_r, elapsed_nxt;
  logic [16:0]   frozen_r, frozen_nxt;
  logic [16:0]   lap_r   [LAP_SLOTS];
  logic [16:0]   lap_nxt [LAP_SLOTS];
  logic [LW-1:0] phase_r, phase_nxt;
  logic [15:0]   echo_r, echo_nxt;
  logic          high_r, high_nxt;
  logic          trig_r, trig_nxt;

  // working registers
  logic [7:0]    rem_r, rem_nxt;
  logic [15:0]   quo_r, quo_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [7:0]    dist_r, dist_nxt;
  logic [16:0]   work_r, work_nxt;
  logic [3:0]    dig_r   [4];
  logic [3:0]    dig_nxt [4];

  logic [7:0]    div_eff;
  logic [8:0]    rem_sh;
  logic          div_ge;
  logic [7:0]    q8, c1;
  logic [3:0]    sel4;
  logic [IW-1:0] lap_idx;
  logic [16:0]   shown;
  logic [16:0]   kval;
  logic          dig_ge;
  logic [3:0]    phase4;

  assign div_eff = (cfg.ticks_per_unit == 8'd0) ? 8'd1 : cfg.ticks_per_unit;
  assign rem_sh  = {rem_r, quo_r[15]};
  assign div_ge  = rem_sh >= {1'b0, div_eff};

  assign q8 = (quo_r > 16'd255) ? 8'hFF : quo_r[7:0];
  // ceiling first, then floor, so the floor wins when they cross
  assign c1 = (q8 >= cfg.distance_ceiling) ? cfg.distance_ceiling : q8;

  assign sel4    = {2'b00, sel_r};
  assign lap_idx = (sel4 >= 4'(LAP_SLOTS)) ? IW'(LAP_SLOTS - 1) : IW'(sel4);
  assign shown   = (phase_r == LAST_PHASE) ? lap_r[lap_idx] :
                   paused_r ? frozen_r : elapsed_r;

  assign kval   = scaled_const(ctrl.csel);
  assign dig_ge = work_r >= kval;

  always_comb begin
    mode_nxt    = mode_r;
    paused_nxt  = paused_r;
    elapsed_nxt = elapsed_r;
    frozen_nxt  = frozen_r;
    lap_nxt     = lap_r;
    phase_nxt   = phase_r;
    echo_nxt    = echo_r;
    high_nxt    = high_r;
    trig_nxt    = trig_r;
    if (ctrl.op == DP_UPDATE) begin
      trig_nxt = 1'b0;
      case (op_r)
        EV_TICK: begin
          if (!mode_r) begin
            elapsed_nxt = (elapsed_r >= WRAP_LAST) ? 17'd0 : elapsed_r + 17'd1;
          end else if (high_r && echo_r != ECHO_MAX) begin
            echo_nxt = echo_r + 16'd1;
          end
        end
        EV_PAUSE: begin
          if (!mode_r) begin
            if (!paused_r) begin
              paused_nxt = 1'b1;
              frozen_nxt = elapsed_r;
            end else begin
              paused_nxt  = 1'b0;
              elapsed_nxt = 17'd0;
              phase_nxt   = '0;
            end
          end else begin
            trig_nxt = 1'b1;
          end
        end
        EV_LAP: begin
          if (!mode_r) begin
            if (phase_r == LAST_PHASE) begin
              elapsed_nxt = 17'd0;
              phase_nxt   = '0;
            end else begin
              lap_nxt[IW'(phase_r)] = elapsed_r;
              phase_nxt             = phase_r + LW'(1);
            end
          end
        end
        EV_MODE: begin
          mode_nxt = !mode_r;
          trig_nxt = !mode_r;
        end
        EV_RISE: begin
          if (mode_r && !high_r) begin
            echo_nxt = 16'd0;
            high_nxt = 1'b1;
          end
        end
        EV_FALL: begin
          if (mode_r && high_r) begin
            high_nxt = 1'b0;
          end
        end
        default: begin
          trig_nxt = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    dist_nxt = dist_r;
    work_nxt = work_r;
    dig_nxt  = dig_r;
    case (ctrl.op)
      DP_DIVINI: begin
        rem_nxt = 8'd0;
        quo_nxt = echo_r;
        cnt_nxt = 4'd0;
      end
      DP_DIVSTP: begin
        rem_nxt = div_ge ? 8'(rem_sh - {1'b0, div_eff}) : rem_sh[7:0];
        quo_nxt = {quo_r[14:0], div_ge};
        cnt_nxt = cnt_r + 4'd1;
      end
      DP_CLAMP: begin
        dist_nxt = (c1 <= cfg.distance_floor) ? cfg.distance_floor : c1;
      end
      DP_DIGLD: begin
        work_nxt = mode_r ? {9'd0, dist_r} : shown;
        dig_nxt  = '{default: 4'd0};
      end
      DP_DIGSTP: begin
        if (ctrl.cond == C_REM) begin
          dig_nxt[0] = work_r[3:0];
        end else begin
          if (dig_ge) begin
            work_nxt = work_r - kval;
          end
          dig_nxt[ctrl.dsel] = {dig_r[ctrl.dsel][2:0], dig_ge};
        end
      end
      default: begin
        rem_nxt = rem_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      paused_r  <= 1'b0;
      elapsed_r <= 17'd0;
      frozen_r  <= 17'd0;
      lap_r     <= '{default: 17'd0};
      phase_r   <= '0;
      echo_r    <= 16'd0;
      high_r    <= 1'b0;
      trig_r    <= 1'b0;
      cnt_r     <= 4'd0;
    end else begin
      mode_r    <= mode_nxt;
      paused_r  <= paused_nxt;
      elapsed_r <= elapsed_nxt;
      frozen_r  <= frozen_nxt;
      lap_r     <= lap_nxt;
      phase_r   <= phase_nxt;
      echo_r    <= echo_nxt;
      high_r    <= high_nxt;
      trig_r    <= trig_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_operation;
      sel_r <= in_lap_select;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dist_r <= dist_nxt;
    work_r <= work_nxt;
    dig_r  <= dig_nxt;
  end

  assign loop_done = (cnt_r == 4'hF);
  assign ranging   = mode_r;
  assign phase4    = 4'(phase_r);

  assign res.ranging_active = mode_r;
  assign res.digit_three    = dig_r[3];
  assign res.digit_two      = dig_r[2];
  assign res.digit_one      = dig_r[1];
  assign res.digit_zero     = dig_r[0];
  assign res.lap_phase_out  = phase4[1:0];
  assign res.paused_out     = paused_r;
  assign res.distance_out   = dist_r;
  assign res.pwm_compare    = {dist_r, 3'b000};
  assign res.trigger_pulse  = trig_r;

  `SEWR_ASSERT_HOLDS(a_elapsed_range, elapsed_r <= WRAP_LAST, "elapsed count out of range")
  `SEWR_ASSERT_HOLDS(a_phase_range, phase_r <= LAST_PHASE, "lap phase past last slot")
  `SEWR_ASSERT_IMPLIES(a_div_rem, ctrl.op == DP_CLAMP, rem_r < div_eff, "divider remainder too big")
  `SEWR_ASSERT_IMPLIES(a_digits_bcd, ctrl.op == DP_EMIT, dig_r[3] <= 4'd9 && dig_r[2] <= 4'd9 && dig_r[1] <= 4'd9 && dig_r[0] <= 4'd9, "digit not bcd")

endmodule

@@ hdl/stopwatch_and_echo_ranger_core.sv @@
`timescale 1ns / 1ps
// items are taken one at a time, only at the wait step; the pace is set by the 16-step
//   restoring divide loop and the per-bit decade subtract steps of the microcode program
// the result register lets the next item be taken while the last result waits
// reset: synchronous active-low rst_n clears the step counter, the result valid,
//   all timer state and loads the register defaults 1, 2 and 20
// ----------------------------------------------------------------------------
// stopwatch_and_echo_ranger_core
// dual-mode stopwatch and echo ranger driven by a microcoded sequencer
// ----------------------------------------------------------------------------
module stopwatch_and_echo_ranger_core #(
  parameter int LAP_SLOTS = sewr_pkg::LAP_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  sewr_in_if.sink                              in_if,
  sewr_out_if.source                           out_if,
  input  logic                                 cfg_we,
  input  logic [sewr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sewr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sewr_pkg::*;

  ctrl_t   ctrl;
  status_t stat;
  cfg_t    cfg_r, cfg_nxt;
  res_t    res, res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    in_fire, out_free, emit;
  logic    loop_done, ranging;

  assign in_if.ready = (ctrl.op == DP_WAIT);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign emit        = (ctrl.op == DP_EMIT) && out_free;

  assign stat.in_fire   = in_fire;
  assign stat.out_free  = out_free;
  assign stat.loop_done = loop_done;
  assign stat.ranging   = ranging;

  sewr_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  sewr_datapath #(
    .LAP_SLOTS (LAP_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_fire       (in_fire),
    .in_operation  (in_if.operation),
    .in_lap_select (in_if.lap_select),
    .cfg           (cfg_r),
    .loop_done     (loop_done),
    .ranging       (ranging),
    .res           (res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TPU:   cfg_nxt.ticks_per_unit   = cfg_data;
        CFG_FLOOR: cfg_nxt.distance_floor   = cfg_data;
        CFG_CEIL:  cfg_nxt.distance_ceiling = cfg_data;
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_unit   <= TPU_RST;
      cfg_r.distance_floor   <= FLOOR_RST;
      cfg_r.distance_ceiling <= CEIL_RST;
      out_valid_r            <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register, loaded on the emit step
  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.ranging_active = res_r.ranging_active;
  assign out_if.digit_three    = res_r.digit_three;
  assign out_if.digit_two      = res_r.digit_two;
  assign out_if.digit_one      = res_r.digit_one;
  assign out_if.digit_zero     = res_r.digit_zero;
  assign out_if.lap_phase_out  = res_r.lap_phase_out;
  assign out_if.paused_out     = res_r.paused_out;
  assign out_if.distance_out   = res_r.distance_out;
  assign out_if.pwm_compare    = res_r.pwm_compare;
  assign out_if.trigger_pulse  = res_r.trigger_pulse;

endmodule

@@ tb/sewr_display_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sewr_display_check
// watches the event and display channels and the register port, keeps its
// own copy of the timer, ranger and register state, works out the display
// item owed for every accepted event and compares each returned item field
// by field against the oldest one owed
// ----------------------------------------------------------------------------
module sewr_display_check #(
  parameter int LAP_SLOTS = sewr_pkg::LAP_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sewr_in_if                              ev_ch,
  sewr_out_if                             disp_ch,
  input  logic                            cfg_we,
  input  logic [sewr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sewr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fault_count,
  output int                              backlog
);
  import sewr_pkg::*;

  logic [7:0]  tpu_r, floor_r, ceil_r;
  logic        ranging, paused, echo_hi;
  logic [16:0] elapsed, frozen;
  logic [16:0] laps [LAP_SLOTS];
  int          lap_phase;
  logic [15:0] echo_cnt;

  res_t display_q[$];
  res_t want;

  // applies one event to the model state and returns the display it leaves
  function automatic res_t next_display(input logic [2:0] op, input logic [1:0] sel);
    res_t        r;
    logic [16:0] shown;
    logic [15:0] quo;
    logic [7:0]  span;
    int          slot;
    logic        trig;
    trig = 1'b0;
    case (op)
      EV_TICK: begin
        if (!ranging) elapsed = (elapsed == WRAP_LAST) ? 17'd0 : elapsed + 17'd1;
        else if (echo_hi && echo_cnt != ECHO_MAX) echo_cnt = echo_cnt + 16'd1;
      end
      EV_PAUSE: begin
        if (ranging) begin
          trig = 1'b1;
        end else if (!paused) begin
          paused = 1'b1;
          frozen = elapsed;
        end else begin
          paused    = 1'b0;
          elapsed   = '0;
          lap_phase = 0;
        end
      end
      EV_LAP: begin
        if (!ranging) begin
          if (lap_phase < LAP_SLOTS) laps[lap_phase] = elapsed;
          else elapsed = '0;
          lap_phase = (lap_phase >= LAP_SLOTS) ? 0 : lap_phase + 1;
        end
      end
      EV_MODE: begin
        ranging = !ranging;
        trig    = ranging;
      end
      EV_RISE: begin
        if (ranging && !echo_hi) begin
          echo_cnt = '0;
          echo_hi  = 1'b1;
        end
      end
      EV_FALL: begin
        if (ranging && echo_hi) echo_hi = 1'b0;
      end
      default: ;
    endcase

    // zero divisor counts as one, quotient saturates before the clamp
    quo  = echo_cnt / ((tpu_r == 8'd0) ? 16'd1 : {8'd0, tpu_r});
    span = (quo > 16'd255) ? 8'd255 : quo[7:0];
    if (span >= ceil_r) span = ceil_r;
    if (span <= floor_r) span = floor_r;

    slot = (sel >= LAP_SLOTS) ? LAP_SLOTS - 1 : int'(sel);
    if (lap_phase == LAP_SLOTS) shown = laps[slot];
    else if (paused) shown = frozen;
    else shown = elapsed;

    r.ranging_active = ranging;
    if (!ranging) begin
      r.digit_three = 4'(shown / 17'd10000);
      r.digit_two   = 4'((shown % 17'd10000) / 17'd1000);
      r.digit_one   = 4'((shown % 17'd1000) / 17'd100);
      r.digit_zero  = 4'((shown % 17'd100) / 17'd10);
    end else begin
      r.digit_three = 4'd0;
      r.digit_two   = 4'(span / 8'd100);
      r.digit_one   = 4'((span % 8'd100) / 8'd10);
      r.digit_zero  = 4'(span % 8'd10);
    end
    r.lap_phase_out = 2'(lap_phase);
    r.paused_out    = paused;
    r.distance_out  = span;
    r.pwm_compare   = {span, 3'b000};
    r.trigger_pulse = trig;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      fault_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tpu_r     = TPU_RST;
      floor_r   = FLOOR_RST;
      ceil_r    = CEIL_RST;
      ranging   = 1'b0;
      paused    = 1'b0;
      echo_hi   = 1'b0;
      elapsed   = '0;
      frozen    = '0;
      lap_phase = 0;
      echo_cnt  = '0;
      foreach (laps[i]) laps[i] = '0;
      display_q.delete();
      fault_count = 0;
      backlog <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TPU:   tpu_r   = cfg_data;
          CFG_FLOOR: floor_r = cfg_data;
          CFG_CEIL:  ceil_r  = cfg_data;
          default: ;
        endcase
      end
      // results leave before the new event is predicted: the latency keeps them apart
      if (disp_ch.valid && disp_ch.ready) begin
        if (display_q.size() == 0) begin
          fault_count++;
          $display("%0t: display item with none pending, got %h", $time,
                   {disp_ch.ranging_active, disp_ch.digit_three, disp_ch.digit_two,
                    disp_ch.digit_one, disp_ch.digit_zero, disp_ch.lap_phase_out,
                    disp_ch.paused_out, disp_ch.distance_out, disp_ch.pwm_compare,
                    disp_ch.trigger_pulse});
        end else begin
          want = display_q.pop_front();
          check_field("ranging_active", want.ranging_active, disp_ch.ranging_active);
          check_field("digit_three", want.digit_three, disp_ch.digit_three);
          check_field("digit_two", want.digit_two, disp_ch.digit_two);
          check_field("digit_one", want.digit_one, disp_ch.digit_one);
          check_field("digit_zero", want.digit_zero, disp_ch.digit_zero);
          check_field("lap_phase_out", want.lap_phase_out, disp_ch.lap_phase_out);
          check_field("paused_out", want.paused_out, disp_ch.paused_out);
          check_field("distance_out", want.distance_out, disp_ch.distance_out);
          check_field("pwm_compare", want.pwm_compare, disp_ch.pwm_compare);
          check_field("trigger_pulse", want.trigger_pulse, disp_ch.trigger_pulse);
        end
      end
      if (ev_ch.valid && ev_ch.ready)
        display_q.push_back(next_display(ev_ch.operation, ev_ch.lap_select));
      backlog <= display_q.size();
    end
  end

endmodule

@@ tb/stopwatch_and_echo_ranger_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stopwatch_and_echo_ranger_core_test
// drives events into the stopwatch and echo ranger: a directed walk through
// laps, pause, unused codes, ignored edges and mode changes, then random
// stopwatch runs, echo measurements and noise under several register
// settings and idling patterns; the checker beside the block judges results
// ----------------------------------------------------------------------------
module stopwatch_and_echo_ranger_core_test;
  import sewr_pkg::*;

  // codes the block treats as no-ops
  localparam logic [2:0] EV_SPARE_LO = 3'd6;
  localparam logic [2:0] EV_SPARE_HI = 3'd7;

  localparam int NUM_SETTINGS      = 6;
  localparam int ITEMS_PER_SETTING = 315;
  localparam int LONG_ECHO_TICKS   = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   send_idle, recv_idle;
  int   fault_count, backlog;
  int   events_sent, target, pick, drain_wait;
  logic ranging_now;

  // per setting: divisor, floor, ceiling and longest echo in ticks
  logic [7:0] tpu_set   [NUM_SETTINGS] = '{8'd0, 8'd255, 8'd1, 8'd1, 8'd3, 8'd7};
  logic [7:0] floor_set [NUM_SETTINGS] = '{8'd0, 8'd0, 8'd10, 8'd200, 8'd5, 8'd255};
  logic [7:0] ceil_set  [NUM_SETTINGS] = '{8'd255, 8'd255, 8'd40, 8'd50, 8'd100, 8'd0};
  int         echo_max  [NUM_SETTINGS] = '{40, 60, 60, 40, 120, 40};

  sewr_in_if  ev_ch();
  sewr_out_if disp_ch();

  stopwatch_and_echo_ranger_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (ev_ch),
    .out_if    (disp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sewr_display_check display_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev_ch       (ev_ch),
    .disp_ch     (disp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fault_count (fault_count),
    .backlog     (backlog)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    disp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic send_event(input logic [2:0] op, input logic [1:0] sel);
    while ($urandom_range(0, 99) < send_idle) begin
      ev_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ev_ch.valid      <= 1'b1;
    ev_ch.operation  <= op;
    ev_ch.lap_select <= sel;
    do @(posedge clk); while (!ev_ch.ready);
    if (op == EV_MODE) ranging_now = !ranging_now;
    events_sent++;
  endtask

  // lets every owed display item come back, then the block's own latency
  task automatic settle();
    ev_ch.valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] tpu, input logic [7:0] flr,
                               input logic [7:0] ceil);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TPU;
    cfg_data  <= tpu;
    @(posedge clk);
    cfg_index <= CFG_FLOOR;
    cfg_data  <= flr;
    @(posedge clk);
    cfg_index <= CFG_CEIL;
    cfg_data  <= ceil;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic stopwatch_run(input int count);
    int r;
    if (ranging_now) send_event(EV_MODE, 2'($urandom_range(0, 3)));
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 75) send_event(EV_TICK, 2'($urandom_range(0, 3)));
      else if (r < 83) send_event(EV_PAUSE, 2'($urandom_range(0, 3)));
      else if (r < 95) send_event(EV_LAP, 2'($urandom_range(0, 3)));
      else send_event(3'($urandom_range(4, 7)), 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic echo_measure(input int ticks);
    if (!ranging_now) send_event(EV_MODE, 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 3) != 0) send_event(EV_PAUSE, 2'($urandom_range(0, 3)));
    send_event(EV_RISE, 2'($urandom_range(0, 3)));
    repeat (ticks) begin
      // a stray rise mid-pulse must not restart the count
      if ($urandom_range(0, 19) == 0) send_event(EV_RISE, 2'($urandom_range(0, 3)));
      send_event(EV_TICK, 2'($urandom_range(0, 3)));
    end
    send_event(EV_FALL, 2'($urandom_range(0, 3)));
    repeat ($urandom_range(0, 2)) send_event(EV_TICK, 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 4) == 0) send_event(EV_FALL, 2'($urandom_range(0, 3)));
  endtask

  initial begin
    ev_ch.valid      = 1'b0;
    ev_ch.operation  = EV_TICK;
    ev_ch.lap_select = 2'd0;
    disp_ch.ready    = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_TPU;
    cfg_data         = '0;
    rst_n            = 1'b0;
    send_idle        = 22;
    recv_idle        = 64;
    events_sent      = 0;
    ranging_now      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk at the reset register values
    send_event(EV_TICK, 2'd0);
    send_event(EV_TICK, 2'd3);
    send_event(EV_LAP, 2'd0);
    send_event(EV_TICK, 2'd0);
    send_event(EV_LAP, 2'd1);
    send_event(EV_LAP, 2'd2);
    send_event(EV_TICK, 2'd3);
    send_event(EV_TICK, 2'd1);
    send_event(EV_SPARE_LO, 2'd2);
    send_event(EV_SPARE_HI, 2'd0);
    send_event(EV_LAP, 2'd0);
    send_event(EV_PAUSE, 2'd0);
    send_event(EV_TICK, 2'd0);
    send_event(EV_PAUSE, 2'd0);
    send_event(EV_RISE, 2'd0);
    send_event(EV_FALL, 2'd0);
    send_event(EV_MODE, 2'd0);
    send_event(EV_LAP, 2'd0);
    send_event(EV_PAUSE, 2'd0);
    send_event(EV_FALL, 2'd0);
    send_event(EV_RISE, 2'd0);
    send_event(EV_TICK, 2'd0);
    send_event(EV_RISE, 2'd0);
    send_event(EV_FALL, 2'd0);
    send_event(EV_MODE, 2'd0);
    settle();

    target = events_sent;
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s < 2) begin
        send_idle = 22;
        recv_idle = 64;
      end else if (s < 4) begin
        send_idle = 64;
        recv_idle = 22;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      load_settings(tpu_set[s], floor_set[s], ceil_set[s]);
      target += ITEMS_PER_SETTING;
      // one long pulse pushes the quotient past 255
      if (s == 0) echo_measure(LONG_ECHO_TICKS);
      while (events_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          stopwatch_run($urandom_range(4, 30));
        end else if (pick < 80) begin
          echo_measure($urandom_range(0, echo_max[s]));
        end else begin
          repeat ($urandom_range(1, 8))
            send_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
        end
      end
      settle();
    end

    drain_wait = 0;
    while (backlog != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (40) @(posedge clk);
    if (fault_count == 0 && backlog == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sewr_pkg.sv
hdl/sewr_in_if.sv
hdl/sewr_out_if.sv
hdl/sewr_useq.sv
hdl/sewr_datapath.sv
hdl/stopwatch_and_echo_ranger_core.sv
tb/sewr_display_check.sv
tb/stopwatch_and_echo_ranger_core_test.sv
